/* rtl/nnt_pkg.sv */
`default_nettype none
package nnt_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned CoordW = 16;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned LenW   = 23;

  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CmdW-1:0] CMD_APPEND = 2'd1;
  localparam logic [CmdW-1:0] CMD_RUN    = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [IdxW-1:0]   start_city;
  } nnt_in_t;

  typedef struct packed {
    logic [IdxW-1:0] city_index;
    logic [LenW-1:0] tour_length;
    logic            last;
    logic            empty_res;
  } nnt_out_t;

endpackage
`default_nettype wire

/* rtl/nnt_ram.sv */
`default_nettype none
module nnt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/nearest_neighbor_tour.sv */
`default_nettype none
// Greedy nearest-neighbor round trip over up to MAX_CITIES stored cities.
// A transaction is accepted at a rising edge where start is high and busy is
// low. Its command selects clear, append or run. Clear, append and unknown
// commands complete at the accepting edge; busy stays low and no result is
// given. A run starts at the given city, clamped to the last loaded city, and
// emits one result per city in tour order, each shown for one cycle with
// valid_o high. The last one carries last and the total round-trip length
// including the closing edge. A run with no cities gives one result with
// empty_res set, in the cycle after acceptance.
// Coordinates live in one synchronous RAM. Each distance takes one read, an
// absolute difference, the squares of both differences and a COORD_BITS+1
// step square root. Each hop scans every stored city, skips visited ones and
// keeps the nearest. The first result is registered once the current city's
// coordinates are read in S_CUR and S_CURW, and busy goes low in the cycle after
// the last result. The receiver cannot stall results. Reset clears the city
// count and the control state; stored coordinates are undefined until written.
module nearest_neighbor_tour #(
  parameter int unsigned MAX_CITIES = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire nnt_pkg::nnt_in_t in_i,
  output logic                  busy,
  output logic                  valid_o,
  output nnt_pkg::nnt_out_t     out_o
);
  import nnt_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_CITIES);
  localparam int unsigned CntW = $clog2(MAX_CITIES + 1);
  localparam int unsigned RtW  = COORD_BITS + 1;
  localparam int unsigned SqW  = 2 * RtW;
  localparam int unsigned PW   = 2 * COORD_BITS;
  localparam int unsigned StW  = $clog2(RtW + 1);
  localparam int unsigned SumW = ((LenW > RtW) ? LenW : RtW) + 1;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_CUR, S_CURW, S_SCAN, S_DIFF, S_SQX, S_SQY, S_ROOT, S_CMP, S_HOPEND, S_DONE
  } state_e;

  state_e                state_q;
  logic [CntW-1:0]       count_q;
  logic [MAX_CITIES-1:0] visited_q;
  logic [AW-1:0]         cur_q, start_q, scan_q, best_q;
  logic [CntW-1:0]       hop_q;
  logic                  closing_q;
  logic [RtW-1:0]        best_d_q;
  logic [LenW-1:0]       len_q;
  logic [COORD_BITS-1:0] cx_q, cy_q, dx_q, dy_q;
  logic [SqW-1:0]        sq_q, rem_q;
  logic [RtW-1:0]        root_q;
  logic [StW-1:0]        step_q;
  logic                  valid_q;
  logic                  busy_q;
  nnt_out_t              res_q;

  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [2*COORD_BITS-1:0] wdata, rdata;
  logic [COORD_BITS-1:0]   rx, ry;

  assign rx = rdata[2*COORD_BITS-1:COORD_BITS];
  assign ry = rdata[COORD_BITS-1:0];
  assign we = start && !busy_q && in_i.cmd == CMD_APPEND && count_q < CntW'(MAX_CITIES);
  assign waddr = count_q[AW-1:0];
  assign wdata = {COORD_BITS'(in_i.coord_x), COORD_BITS'(in_i.coord_y)};

  nnt_ram #(.Width(2 * COORD_BITS), .Depth(MAX_CITIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    raddr = scan_q;
    if (state_q == S_CUR) begin
      raddr = cur_q;
    end
  end

  // Restoring square root, one result bit per cycle.
  logic [SqW-1:0] trial, rem_sh;
  always_comb begin
    rem_sh = {rem_q[SqW-3:0], sq_q[SqW-1:SqW-2]};
    trial  = SqW'({root_q, 2'b01});
  end

  logic [COORD_BITS-1:0] ddx, ddy;
  assign ddx = cx_q > rx ? cx_q - rx : rx - cx_q;
  assign ddy = cy_q > ry ? cy_q - ry : ry - cy_q;

  logic [COORD_BITS-1:0] mul_a;
  logic [PW-1:0]         prod;
  assign mul_a = (state_q == S_SQX) ? dx_q : dy_q;
  assign prod  = PW'(mul_a) * PW'(mul_a);

  logic [RtW-1:0]  hop_dist, add_val;
  logic [SumW-1:0] len_sum;
  logic [LenW-1:0] len_sat;
  assign hop_dist = (rem_q > SqW'(root_q)) ? root_q + RtW'(1) : root_q;
  assign add_val  = (state_q == S_CMP) ? hop_dist : best_d_q;
  assign len_sum  = SumW'(len_q) + SumW'(add_val);
  assign len_sat  = (len_sum > SumW'(LenMax)) ? LenMax : len_sum[LenW-1:0];

  logic            start_ge;
  logic [CntW-1:0] count_m1;
  logic [AW-1:0]   st_clamp;
  assign start_ge = (IdxW+1)'(in_i.start_city) >= (IdxW+1)'(count_q);
  assign count_m1 = count_q - CntW'(1);
  assign st_clamp = start_ge ? count_m1[AW-1:0] : in_i.start_city[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      visited_q <= '0;
      cur_q     <= '0;
      start_q   <= '0;
      scan_q    <= '0;
      best_q    <= '0;
      hop_q     <= '0;
      closing_q <= 1'b0;
      best_d_q  <= '0;
      len_q     <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      sq_q      <= '0;
      rem_q     <= '0;
      root_q    <= '0;
      step_q    <= '0;
      valid_q   <= 1'b0;
      busy_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start && !busy_q) begin
            if (in_i.cmd == CMD_CLEAR) begin
              count_q   <= '0;
              visited_q <= '0;
            end else if (we) begin
              count_q <= count_q + CntW'(1);
            end else if (in_i.cmd == CMD_RUN) begin
              busy_q <= 1'b1;
              if (count_q == '0) begin
                res_q   <= '{city_index: '0, tour_length: '0, last: 1'b1, empty_res: 1'b1};
                valid_q <= 1'b1;
                state_q <= S_DONE;
              end else begin
                cur_q     <= st_clamp;
                start_q   <= st_clamp;
                visited_q <= '0;
                visited_q[st_clamp] <= 1'b1;
                len_q     <= '0;
                hop_q     <= CntW'(1);
                closing_q <= 1'b0;
                state_q   <= S_CUR;
              end
            end
          end
        end
        S_CUR: state_q <= S_CURW;
        S_CURW: begin
          cx_q     <= rx;
          cy_q     <= ry;
          best_d_q <= '1;
          best_q   <= cur_q;
          if (hop_q >= count_q) begin
            closing_q <= 1'b1;
            scan_q    <= start_q;
          end else begin
            res_q   <= '{city_index: IdxW'(cur_q), tour_length: '0, last: 1'b0, empty_res: 1'b0};
            valid_q <= 1'b1;
            scan_q  <= '0;
          end
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (!closing_q && visited_q[scan_q]) begin
            if (CntW'(scan_q) + CntW'(1) >= count_q) begin
              state_q <= S_HOPEND;
            end else begin
              scan_q <= scan_q + AW'(1);
            end
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          dx_q    <= ddx;
          dy_q    <= ddy;
          state_q <= S_SQX;
        end
        S_SQX: begin
          sq_q    <= SqW'(prod);
          state_q <= S_SQY;
        end
        S_SQY: begin
          sq_q    <= sq_q + SqW'(prod);
          step_q  <= '0;
          rem_q   <= '0;
          root_q  <= '0;
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[RtW-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[RtW-2:0], 1'b0};
          end
          sq_q   <= {sq_q[SqW-3:0], 2'b00};
          step_q <= step_q + StW'(1);
          if (step_q == StW'(RtW - 1)) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (closing_q) begin
            len_q   <= len_sat;
            res_q   <= '{city_index: IdxW'(cur_q), tour_length: len_sat, last: 1'b1,
                         empty_res: 1'b0};
            valid_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            if (hop_dist < best_d_q) begin
              best_d_q <= hop_dist;
              best_q   <= scan_q;
            end
            if (CntW'(scan_q) + CntW'(1) >= count_q) begin
              state_q <= S_HOPEND;
            end else begin
              scan_q  <= scan_q + AW'(1);
              state_q <= S_SCAN;
            end
          end
        end
        S_HOPEND: begin
          visited_q[best_q] <= 1'b1;
          len_q   <= len_sat;
          cur_q   <= best_q;
          hop_q   <= hop_q + CntW'(1);
          state_q <= S_CUR;
        end
        S_DONE: begin
          busy_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy    = busy_q;
  assign valid_o = valid_q;
  assign out_o   = res_q;

`ifndef SYNTHESIS
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> busy);
  a_valid_gap: assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o);
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.empty_res |-> out_o.last);
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_CITIES));
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
module tb;
  import nnt_pkg::*;

  localparam int unsigned NumCities = 64;
  localparam int unsigned ItemGoal = 410;
  localparam int unsigned NumDirRows = 17;
  localparam logic [CmdW-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    nnt_in_t  item;
    bit       has_exp;
    nnt_out_t exp;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  nnt_in_t  in_i;
  logic     busy;
  logic     valid_o;
  nnt_out_t out_o;

  logic [CoordW-1:0] city_x[NumCities];
  logic [CoordW-1:0] city_y[NumCities];
  int unsigned       loaded_cities;
  nnt_out_t          tour_q[$];
  int unsigned       mismatches;
  int unsigned       items_sent;
  dir_row_t          dir_rows[NumDirRows];

  nearest_neighbor_tour uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .in_i   (in_i),
    .busy   (busy),
    .valid_o(valid_o),
    .out_o  (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint unsigned rounded_dist(int unsigned a, int unsigned b);
    longint unsigned dx, dy, s, r, t;
    dx = city_x[a] > city_x[b] ? city_x[a] - city_x[b] : city_x[b] - city_x[a];
    dy = city_y[a] > city_y[b] ? city_y[a] - city_y[b] : city_y[b] - city_y[a];
    s = dx * dx + dy * dy;
    r = 0;
    for (int bit_i = 17; bit_i >= 0; bit_i--) begin
      t = r | (64'd1 << bit_i);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  // Updates the city list and returns the tour the block should emit.
  function automatic void predict_tour(input nnt_in_t item, output nnt_out_t tour[$]);
    int unsigned     first, here, best;
    longint unsigned best_d, d, total;
    bit              seen[NumCities];
    nnt_out_t        res;
    tour = {};
    case (item.cmd)
      CMD_CLEAR: loaded_cities = 0;
      CMD_APPEND: begin
        if (loaded_cities < NumCities) begin
          city_x[loaded_cities] = item.coord_x;
          city_y[loaded_cities] = item.coord_y;
          loaded_cities++;
        end
      end
      CMD_RUN: begin
        if (loaded_cities == 0) begin
          res = '{city_index: '0, tour_length: '0, last: 1'b1, empty_res: 1'b1};
          tour.push_back(res);
        end else begin
          first = item.start_city;
          if (first >= loaded_cities) first = loaded_cities - 1;
          foreach (seen[i]) seen[i] = 1'b0;
          seen[first] = 1'b1;
          here = first;
          total = 0;
          for (int hop = 1; hop < loaded_cities; hop++) begin
            res = '{city_index: here[IdxW-1:0], tour_length: '0, last: 1'b0,
                    empty_res: 1'b0};
            tour.push_back(res);
            best = here;
            best_d = '1;
            for (int i = 0; i < loaded_cities; i++) begin
              if (!seen[i]) begin
                d = rounded_dist(here, i);
                if (d < best_d) begin
                  best_d = d;
                  best = i;
                end
              end
            end
            seen[best] = 1'b1;
            total += best_d;
            here = best;
          end
          total += rounded_dist(here, first);
          if (total > (1 << LenW) - 1) total = (1 << LenW) - 1;
          res = '{city_index: here[IdxW-1:0], tour_length: total[LenW-1:0], last: 1'b1,
                  empty_res: 1'b0};
          tour.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input nnt_in_t item, input bit has_exp, input nnt_out_t exp);
    nnt_out_t tour[$];
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    in_i = item;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_tour(item, tour);
    if (has_exp) begin
      tour.delete();
      tour.push_back(exp);
    end
    foreach (tour[i]) tour_q.push_back(tour[i]);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [CmdW-1:0] cmd, input int unsigned x,
                          input int unsigned y, input int unsigned city);
    nnt_in_t item;
    item = '{cmd: cmd, coord_x: x[CoordW-1:0], coord_y: y[CoordW-1:0],
             start_city: city[IdxW-1:0]};
    send_item(item, 1'b0, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (tour_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    nnt_out_t want;
    if (rst_ni && valid_o) begin
      if (tour_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", out_o);
      end else begin
        want = tour_q.pop_front();
        if (out_o.city_index !== want.city_index || out_o.tour_length !== want.tour_length
            || out_o.last !== want.last || out_o.empty_res !== want.empty_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected idx %0d len %0d last %0d empty %0d, got %0d %0d %0d %0d",
                     want.city_index, want.tour_length, want.last, want.empty_res,
                     out_o.city_index, out_o.tour_length, out_o.last, out_o.empty_res);
        end
      end
    end
  end

  initial begin
    nnt_out_t    none;
    nnt_out_t    empty_tour;
    nnt_out_t    lone_city;
    int unsigned kind, n_app, n_run;
    none = '0;
    empty_tour = '{city_index: '0, tour_length: '0, last: 1'b1, empty_res: 1'b1};
    lone_city = '{city_index: '0, tour_length: '0, last: 1'b1, empty_res: 1'b0};
    mismatches = 0;
    items_sent = 0;
    loaded_cities = 0;
    start = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_rows = '{
      '{'{CMD_RUN, 16'h0000, 16'h0000, 6'd0}, 1'b1, empty_tour},
      '{'{CMD_UNKNOWN, 16'hffff, 16'hffff, 6'd63}, 1'b0, none},
      '{'{CMD_APPEND, 16'h0000, 16'h0000, 6'd0}, 1'b0, none},
      '{'{CMD_RUN, 16'h0000, 16'h0000, 6'd63}, 1'b1, lone_city},
      '{'{CMD_APPEND, 16'hffff, 16'hffff, 6'd0}, 1'b0, none},
      '{'{CMD_APPEND, 16'hffff, 16'h0000, 6'd0}, 1'b0, none},
      '{'{CMD_APPEND, 16'h0000, 16'hffff, 6'd0}, 1'b0, none},
      '{'{CMD_RUN, 16'h0000, 16'h0000, 6'd0}, 1'b0, none},
      '{'{CMD_RUN, 16'h0000, 16'h0000, 6'd5}, 1'b0, none},
      '{'{CMD_UNKNOWN, 16'h0000, 16'h0000, 6'd0}, 1'b0, none},
      '{'{CMD_RUN, 16'h0000, 16'h0000, 6'd1}, 1'b0, none},
      '{'{CMD_CLEAR, 16'h0000, 16'h0000, 6'd0}, 1'b0, none},
      '{'{CMD_RUN, 16'h0000, 16'h0000, 6'd2}, 1'b1, empty_tour},
      '{'{CMD_APPEND, 16'h1234, 16'h1234, 6'd0}, 1'b0, none},
      '{'{CMD_APPEND, 16'h1234, 16'h1234, 6'd0}, 1'b0, none},
      '{'{CMD_APPEND, 16'h1237, 16'h1238, 6'd0}, 1'b0, none},
      '{'{CMD_RUN, 16'h0000, 16'h0000, 6'd2}, 1'b0, none}
    };
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);

    // Fill the store past its capacity so the extra appends are dropped.
    wait_drained();
    send_cmd(CMD_CLEAR, $urandom, $urandom, $urandom);
    for (int i = 0; i < NumCities + 2; i++) send_cmd(CMD_APPEND, $urandom, $urandom, $urandom);
    send_cmd(CMD_RUN, $urandom, $urandom, $urandom);

    while (items_sent < ItemGoal) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        send_cmd($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_CLEAR, $urandom, $urandom, $urandom);
      end else if (kind == 1) begin
        wait_drained();
      end else begin
        send_cmd(CMD_CLEAR, $urandom, $urandom, $urandom);
        n_app = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        for (int i = 0; i < n_app; i++) begin
          if ($urandom_range(0, 3) == 0)
            send_cmd(CMD_APPEND, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
          else
            send_cmd(CMD_APPEND, $urandom, $urandom, $urandom);
        end
        n_run = $urandom_range(1, 3);
        for (int i = 0; i < n_run; i++)
          send_cmd(CMD_RUN, $urandom, $urandom, $urandom_range(0, n_app + 1));
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && tour_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* nearest_neighbor_tour.f */
rtl/nnt_pkg.sv
rtl/nnt_ram.sv
rtl/nearest_neighbor_tour.sv
verif/tb.sv
